FILE: hdl/rrs_pkg.sv
// shared types, constants and sine table function for the radial ripple shader
`default_nettype none

package rrs_pkg;

  // grid and centre of the ripple
  localparam int GRID_W = 8;
  localparam int GRID_H = 8;
  localparam logic [6:0] CENTRE_X = 7'(GRID_W / 2);
  localparam logic [6:0] CENTRE_Y = 7'(GRID_H / 2);

  localparam int SINE_ENTRIES_DEF = 1024;

  // field widths
  localparam int COORD_W = 6;
  localparam int PHASE_W = 16;
  localparam int CHAN_W  = 8;
  localparam int CFG_IDX_W = 8;

  // square root datapath
  localparam int SQ_W   = 14;
  localparam int RAD_W  = SQ_W + 16;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int SQRT_STAGES = 4;
  localparam int SQRT_STEPS  = 4;

  // 2^18 / (2*pi) in the angle to table index mapping
  localparam logic [17:0] ANGLE_GAIN = 18'd41721;

  // accepted transaction to result strobe, in cycles
  localparam int LATENCY = 9;

  // Q30 constants for the table build
  localparam longint PI_HALF_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint TAYLOR_DIV [14] = '{
    64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156, 64'sd210,
    64'sd272, 64'sd342, 64'sd420, 64'sd506, 64'sd600, 64'sd702, 64'sd812
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_RED   = 8'd0,
    CFG_BASE_GREEN = 8'd1,
    CFG_BASE_BLUE  = 8'd2,
    CFG_MAX_LEVEL  = 8'd3
  } rrs_cfg_e;

  // pixel data that rides along the pipeline
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PHASE_W-1:0] phase;
  } rrs_side_t;

  // square root working set between stages
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
    rrs_side_t         side;
  } rrs_root_t;

  // round(32768 * sin(pi/2 * j / (2^log2n / 4))), j in 0..2^log2n/4
  function automatic int rrs_quarter_sine(input int j, input int log2n);
    longint x;
    longint x2;
    longint term;
    longint sum;
    int k;
    x = (PI_HALF_Q30 * longint'(4 * j) + (longint'(1) <<< (log2n - 1))) >>> log2n;
    x2 = (x * x) >>> 30;
    term = x;
    sum = 0;
    for (k = 0; k < 14; k++) begin
      sum = sum + term;
      term = -((term * x2) >>> 30);
      term = term / TAYLOR_DIV[k];
    end
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return int'((sum + (longint'(1) <<< 14)) >>> 15);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rrs_sqrt_stage.sv
// one register stage of the digit-by-digit square root
`default_nettype none

module rrs_sqrt_stage
  import rrs_pkg::*;
#(
  parameter int STEPS = SQRT_STEPS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  rrs_root_t data_i,
  output logic      valid_o,
  output rrs_root_t data_o
);

  logic      valid_q;
  rrs_root_t data_q, data_d;

  always_comb begin
    logic [REM_W+1:0]  work;
    logic [REM_W+1:0]  trial;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
    logic [RAD_W-1:0]  rad;
    root = data_i.root;
    rem  = data_i.rem;
    rad  = data_i.rad;
    for (int k = 0; k < STEPS; k++) begin
      work  = {rem, rad[RAD_W-1 -: 2]};
      trial = {2'b00, root, 2'b01};
      if (work >= trial) begin
        work = work - trial;
        root = {root[ROOT_W-2:0], 1'b1};
      end else begin
        root = {root[ROOT_W-2:0], 1'b0};
      end
      rem = work[REM_W-1:0];
      rad = {rad[RAD_W-3:0], 2'b00};
    end
    data_d      = data_i;
    data_d.root = root;
    data_d.rem  = rem;
    data_d.rad  = rad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: hdl/rrs_sine_level.sv
// angle, sine table lookup and ripple level, three register stages
`default_nettype none

module rrs_sine_level
  import rrs_pkg::*;
#(
  parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  rrs_side_t         side_i,
  input  logic [ROOT_W-1:0] dist_i,
  input  logic [CHAN_W-1:0] max_level_i,
  output logic              valid_o,
  output rrs_side_t         side_o,
  output logic [CHAN_W-1:0] level_o
);

  localparam int IDX_W     = $clog2(SINE_ENTRIES);
  localparam int QUARTER_N = SINE_ENTRIES / 4;
  localparam int QIDX_W    = IDX_W - 1;

  // quarter wave table, entries 0..QUARTER_N
  logic [15:0] quarter_tab [QUARTER_N+1];

  for (genvar g = 0; g <= QUARTER_N; g++) begin : g_tab
    assign quarter_tab[g] = 16'(rrs_quarter_sine(g, IDX_W));
  end

  // stage a: angle times gain
  logic [PHASE_W-1:0] raw;
  logic signed [33:0] prod;
  logic               a_valid_q;
  rrs_side_t          a_side_q;
  logic [IDX_W-1:0]   a_idx_q;

  assign raw  = {1'b0, dist_i} - side_i.phase;
  assign prod = $signed(raw) * $signed(ANGLE_GAIN);

  // stage b: table read
  logic               b_valid_q;
  rrs_side_t          b_side_q;
  logic [15:0]        b_sine_q;
  logic               b_neg_q;
  logic [QIDX_W-1:0]  qidx;
  logic [QIDX_W-1:0]  mpos;

  assign mpos = {1'b0, a_idx_q[IDX_W-3:0]};
  assign qidx = a_idx_q[IDX_W-2] ? (QIDX_W'(QUARTER_N) - mpos) : mpos;

  // stage c: level
  logic               c_valid_q;
  rrs_side_t          c_side_q;
  logic [CHAN_W-1:0]  c_level_q;
  logic [16:0]        shifted;
  logic [24:0]        scaled;

  assign shifted = b_neg_q ? (17'd32768 - {1'b0, b_sine_q})
                           : (17'd32768 + {1'b0, b_sine_q});
  assign scaled  = shifted * max_level_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_side_q  <= side_i;
    a_idx_q   <= prod[25 -: IDX_W];
    b_side_q  <= a_side_q;
    b_sine_q  <= quarter_tab[qidx];
    b_neg_q   <= a_idx_q[IDX_W-1];
    c_side_q  <= b_side_q;
    c_level_q <= scaled[23:16];
  end

  assign valid_o = c_valid_q;
  assign side_o  = c_side_q;
  assign level_o = c_level_q;

endmodule

`default_nettype wire

FILE: hdl/rrs_colour_scale.sv
// scales the base colour by the ripple level, output register stage
`default_nettype none

module rrs_colour_scale
  import rrs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  rrs_side_t          side_i,
  input  logic [CHAN_W-1:0]  level_i,
  input  logic [CHAN_W-1:0]  base_red_i,
  input  logic [CHAN_W-1:0]  base_green_i,
  input  logic [CHAN_W-1:0]  base_blue_i,
  output logic               valid_o,
  output logic [COORD_W-1:0] x_o,
  output logic [COORD_W-1:0] y_o,
  output logic [CHAN_W-1:0]  red_o,
  output logic [CHAN_W-1:0]  green_o,
  output logic [CHAN_W-1:0]  blue_o,
  output logic [CHAN_W-1:0]  level_o
);

  logic [CHAN_W:0]    gain;
  logic [2*CHAN_W:0]  red_prod, green_prod, blue_prod;
  logic               valid_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [CHAN_W-1:0]  red_q, green_q, blue_q, level_q;

  assign gain       = {1'b0, level_i} + 9'd1;
  assign red_prod   = base_red_i * gain;
  assign green_prod = base_green_i * gain;
  assign blue_prod  = base_blue_i * gain;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= side_i.x;
    y_q     <= side_i.y;
    red_q   <= red_prod[2*CHAN_W-1:CHAN_W];
    green_q <= green_prod[2*CHAN_W-1:CHAN_W];
    blue_q  <= blue_prod[2*CHAN_W-1:CHAN_W];
    level_q <= level_i;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;
  assign level_o = level_q;

endmodule

`default_nettype wire

FILE: hdl/radial_ripple_shader.sv
// top level of the radial ripple shader
`default_nettype none

// Radial ripple shader. Give one pixel per clock: a transaction is taken
// whenever start_i is high and busy_o is low. busy_o is high during reset and
// in the first cycle after reset is released and low at all times after that,
// so a full raster can stream without gaps.
// Each pixel's colour comes out marked by a one-cycle done_o; results cannot
// be held off, so the receiver must take them as they come. The pipeline
// holds, in order, the squaring stage, the square root of the pixel's squared
// distance (15 result bits, four stages of up to four digits each), the angle
// multiply, the registered sine table read, the level multiply and the output
// register. The colour and max level registers are written through the cfg
// port and must only change while no pixel is in flight.

module radial_ripple_shader
  import rrs_pkg::*;
#(
  parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // pixel transactions
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [COORD_W-1:0]   pixel_x_i,
  input  logic [COORD_W-1:0]   pixel_y_i,
  input  logic [PHASE_W-1:0]   time_phase_i,
  // results
  output logic                 done_o,
  output logic [COORD_W-1:0]   out_x_o,
  output logic [COORD_W-1:0]   out_y_o,
  output logic [CHAN_W-1:0]    out_red_o,
  output logic [CHAN_W-1:0]    out_green_o,
  output logic [CHAN_W-1:0]    out_blue_o,
  output logic [CHAN_W-1:0]    brightness_o,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CHAN_W-1:0]    cfg_data_i
);

  // registered high once reset is released; gates both channels
  logic run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= 1'b1;
    end
  end

  assign busy_o      = ~run_q;
  assign cfg_ready_o = run_q;

  // configuration registers, writes to unknown indices are dropped
  logic [CHAN_W-1:0] base_red_q, base_green_q, base_blue_q, max_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_red_q   <= '1;
      base_green_q <= '1;
      base_blue_q  <= '1;
      max_level_q  <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BASE_RED:   base_red_q   <= cfg_data_i;
        CFG_BASE_GREEN: base_green_q <= cfg_data_i;
        CFG_BASE_BLUE:  base_blue_q  <= cfg_data_i;
        CFG_MAX_LEVEL:  max_level_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // entry stage: offsets from the centre and squared distance
  logic              accept;
  logic signed [6:0] dx, dy;
  logic signed [13:0] dx2, dy2;
  logic              in_valid_q;
  rrs_side_t         in_side_q;
  logic [SQ_W-1:0]   sq_q;

  assign accept = start_i && !busy_o;
  assign dx  = $signed({1'b0, pixel_x_i}) - $signed(CENTRE_X);
  assign dy  = $signed({1'b0, pixel_y_i}) - $signed(CENTRE_Y);
  assign dx2 = dx * dx;
  assign dy2 = dy * dy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    in_side_q.x     <= pixel_x_i;
    in_side_q.y     <= pixel_y_i;
    in_side_q.phase <= time_phase_i;
    sq_q            <= $unsigned(dx2) + $unsigned(dy2);
  end

  // square root pipeline: root of (sq << 16) is the distance in q7.8
  rrs_root_t             root_pipe [SQRT_STAGES+1];
  logic [SQRT_STAGES:0]  root_vld;

  assign root_vld[0]       = in_valid_q;
  assign root_pipe[0].rad  = {sq_q, 16'b0};
  assign root_pipe[0].root = '0;
  assign root_pipe[0].rem  = '0;
  assign root_pipe[0].side = in_side_q;

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sqrt
    localparam int STEPS = (s == SQRT_STAGES - 1) ?
                           ROOT_W - (SQRT_STAGES - 1) * SQRT_STEPS : SQRT_STEPS;
    rrs_sqrt_stage #(
      .STEPS(STEPS)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(root_vld[s]),
      .data_i (root_pipe[s]),
      .valid_o(root_vld[s+1]),
      .data_o (root_pipe[s+1])
    );
  end

  // angle, sine and level
  logic              lvl_valid;
  rrs_side_t         lvl_side;
  logic [CHAN_W-1:0] lvl;

  rrs_sine_level #(
    .SINE_ENTRIES(SINE_ENTRIES)
  ) u_sine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (root_vld[SQRT_STAGES]),
    .side_i     (root_pipe[SQRT_STAGES].side),
    .dist_i     (root_pipe[SQRT_STAGES].root),
    .max_level_i(max_level_q),
    .valid_o    (lvl_valid),
    .side_o     (lvl_side),
    .level_o    (lvl)
  );

  // colour scaling and output register
  rrs_colour_scale u_colour (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (lvl_valid),
    .side_i      (lvl_side),
    .level_i     (lvl),
    .base_red_i  (base_red_q),
    .base_green_i(base_green_q),
    .base_blue_i (base_blue_q),
    .valid_o     (done_o),
    .x_o         (out_x_o),
    .y_o         (out_y_o),
    .red_o       (out_red_o),
    .green_o     (out_green_o),
    .blue_o      (out_blue_o),
    .level_o     (brightness_o)
  );

endmodule

`default_nettype wire

FILE: hdl/rrs_checker.sv
// port level checks for the radial ripple shader, bound to the top level
`default_nettype none

module rrs_checker
  import rrs_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic [COORD_W-1:0] pixel_x_i,
  input logic [COORD_W-1:0] pixel_y_i,
  input logic               done_o,
  input logic [COORD_W-1:0] out_x_o,
  input logic [COORD_W-1:0] out_y_o,
  input logic [CHAN_W-1:0]  out_red_o,
  input logic [CHAN_W-1:0]  out_green_o,
  input logic [CHAN_W-1:0]  out_blue_o,
  input logic [CHAN_W-1:0]  brightness_o
);

  // every accepted transaction gives its result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LATENCY done_o)
    else $error("result missing after accepted transaction");

  // no result without a transaction the fixed latency earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without a transaction");

  // coordinates come back in order
  a_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> out_x_o == $past(pixel_x_i, LATENCY) &&
               out_y_o == $past(pixel_y_i, LATENCY))
    else $error("coordinates do not match their transaction");

  // a dark level leaves every channel black
  a_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && brightness_o == '0 |-> out_red_o == '0 && out_green_o == '0 &&
                                     out_blue_o == '0)
    else $error("channel lit at zero level");

endmodule

bind radial_ripple_shader rrs_checker u_rrs_checker (.*);

`default_nettype wire

FILE: tb/radial_ripple_shader_tb.sv
// self-checking testbench for the radial ripple shader: pixel stimulus, colour prediction, checks
`timescale 1ns / 1ps

module radial_ripple_shader_tb;
  import rrs_pkg::*;

  // run shape
  localparam int CYCLE_LIMIT       = 200_000;
  localparam int ITEMS_PER_SETTING = 150;
  localparam int NUM_SETTINGS      = 8;
  localparam int MAX_REPORTS       = 10;
  localparam int TABLE_SIZE        = SINE_ENTRIES_DEF;

  // first register index outside the map, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_IDX = CFG_IDX_W'(CFG_MAX_LEVEL + 1);

  // angle (Q8.8 radians) to fraction of a turn, 2^18 / (2*pi)
  localparam longint ANGLE_TO_TURN = 41721;
  // pi/2 and 1.0 in Q30 for the sine table build
  localparam longint HALF_PI_Q30   = 1686629713;
  localparam longint UNITY_Q30     = 1073741824;
  // offset that lifts a signed Q15 sine into 0..65536
  localparam longint SINE_LIFT     = 32768;

  // one pixel colour as the block should produce it
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  level;
  } pixel_colour_t;

  // one pixel request
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PHASE_W-1:0] ph;
  } pixel_req_t;

  // hand-picked pixels: corners, centre, crest and trough of the wave,
  // both ends of the signed angle, off-grid coordinates, alternating bits
  localparam pixel_req_t DIRECTED [18] = '{
    '{6'd0,  6'd0,  16'h0000},   // grid corner
    '{6'd63, 6'd63, 16'hFFFF},   // all ones
    '{6'd4,  6'd4,  16'h0000},   // centre, zero distance, zero phase
    '{6'd4,  6'd4,  16'hFE6D},   // angle lands on the sine crest
    '{6'd4,  6'd4,  16'h0192},   // angle lands on the sine trough
    '{6'd4,  6'd4,  16'h7FFF},   // large negative angle
    '{6'd4,  6'd4,  16'h8000},   // most negative angle
    '{6'd4,  6'd4,  16'h8001},   // most positive angle
    '{6'd5,  6'd4,  16'h0000},   // distance of exactly one
    '{6'd0,  6'd4,  16'h0100},   // negative dx
    '{6'd7,  6'd7,  16'h0200},   // last pixel of the grid
    '{6'd63, 6'd0,  16'h0000},   // off grid, far column
    '{6'd0,  6'd63, 16'hFFFF},   // off grid, far row
    '{6'd32, 6'd17, 16'h1234},
    '{6'd8,  6'd8,  16'h0000},   // just past the grid
    '{6'd42, 6'd21, 16'h5555},   // alternating bits
    '{6'd21, 6'd42, 16'hAAAA},
    '{6'd3,  6'd4,  16'hFF00}
  };

  // colour predictor and store of awaited colours
  class ripple_scoreboard;
    int            sine_q15 [TABLE_SIZE];
    int unsigned   red_reg;
    int unsigned   green_reg;
    int unsigned   blue_reg;
    int unsigned   level_cap;
    pixel_colour_t awaited [$];
    int            accepted;
    int            checked;
    int            failures;

    function new();
      int i;
      int quad;
      int offs;
      red_reg   = 255;
      green_reg = 255;
      blue_reg  = 255;
      level_cap = 255;
      accepted  = 0;
      checked   = 0;
      failures  = 0;
      // full wave from mirrored and negated quarter waves
      for (i = 0; i < TABLE_SIZE; i++) begin
        quad = (4 * i) / TABLE_SIZE;
        offs = (4 * i) % TABLE_SIZE;
        if (quad == 0) sine_q15[i] = quarter_wave(offs);
        else if (quad == 1) sine_q15[i] = quarter_wave(TABLE_SIZE - offs);
        else if (quad == 2) sine_q15[i] = -quarter_wave(offs);
        else sine_q15[i] = -quarter_wave(TABLE_SIZE - offs);
      end
    endfunction

    // rounded Q15 of sin(pi/2 * r / TABLE_SIZE), Taylor series in Q30
    function int quarter_wave(int r);
      longint x;
      longint x_sq;
      longint term;
      longint acc;
      int k;
      x = (HALF_PI_Q30 * longint'(r) + longint'(TABLE_SIZE / 2)) / longint'(TABLE_SIZE);
      x_sq = (x * x) >>> 30;
      term = x;
      acc = 0;
      for (k = 0; k < 14; k++) begin
        acc = acc + term;
        term = -((term * x_sq) >>> 30);
        term = term / longint'((2 * k + 2) * (2 * k + 3));
      end
      if (acc < 0) acc = 0;
      if (acc > UNITY_Q30) acc = UNITY_Q30;
      return int'((acc + (longint'(1) <<< 14)) >>> 15);
    endfunction

    // floor square root, one result bit at a time from the top
    function int unsigned root32(int unsigned v);
      int unsigned acc;
      int unsigned trial;
      int b;
      acc = 0;
      for (b = 15; b >= 0; b--) begin
        trial = acc | (32'd1 << b);
        if (longint'(trial) * longint'(trial) <= longint'(v)) acc = trial;
      end
      return acc;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CHAN_W-1:0] val);
      case (idx)
        CFG_BASE_RED:   red_reg   = val;
        CFG_BASE_GREEN: green_reg = val;
        CFG_BASE_BLUE:  blue_reg  = val;
        CFG_MAX_LEVEL:  level_cap = val;
        default: ;
      endcase
    endfunction

    function pixel_colour_t shade(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                  logic [PHASE_W-1:0] ph);
      int                 dx;
      int                 dy;
      int unsigned        radius;
      logic [PHASE_W-1:0] offset;
      longint             scaled;
      int                 slot;
      longint             lift;
      int unsigned        lvl;
      pixel_colour_t      res;
      dx = int'(x) - GRID_W / 2;
      dy = int'(y) - GRID_H / 2;
      // distance in Q8.8, then angle wrapped to 16 bits and read as signed
      radius = root32(int'(dx * dx + dy * dy) << 16);
      offset = radius[PHASE_W-1:0] - ph;
      scaled = longint'($signed(offset)) * ANGLE_TO_TURN * longint'(TABLE_SIZE);
      // arithmetic shift floors, masking wraps negatives into the table
      slot = int'((scaled >>> 26) & longint'(TABLE_SIZE - 1));
      lift = ((longint'(sine_q15[slot]) + SINE_LIFT) * longint'(level_cap)) >>> 16;
      if (lift < 0) lift = 0;
      if (lift > 255) lift = 255;
      lvl = int'(lift);
      res.x     = x;
      res.y     = y;
      res.red   = CHAN_W'((red_reg * (1 + lvl)) >> 8);
      res.green = CHAN_W'((green_reg * (1 + lvl)) >> 8);
      res.blue  = CHAN_W'((blue_reg * (1 + lvl)) >> 8);
      res.level = CHAN_W'(lvl);
      return res;
    endfunction

    function void note_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [PHASE_W-1:0] ph);
      awaited.push_back(shade(x, y, ph));
      accepted++;
    endfunction

    function void check_colour(pixel_colour_t got);
      pixel_colour_t want;
      checked++;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result at %0t: x=%0d y=%0d", $realtime, got.x, got.y);
        return;
      end
      want = awaited.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.red !== want.red ||
          got.green !== want.green || got.blue !== want.blue ||
          got.level !== want.level) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("colour mismatch at %0t: expected (%0d,%0d) rgb %0d/%0d/%0d lvl %0d, got (%0d,%0d) rgb %0d/%0d/%0d lvl %0d",
                   $realtime, want.x, want.y, want.red, want.green, want.blue,
                   want.level, got.x, got.y, got.red, got.green, got.blue, got.level);
      end
    endfunction
  endclass

  // clock, reset and block ports
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [COORD_W-1:0]   pixel_x_i;
  logic [COORD_W-1:0]   pixel_y_i;
  logic [PHASE_W-1:0]   time_phase_i;
  logic                 done_o;
  logic [COORD_W-1:0]   out_x_o;
  logic [COORD_W-1:0]   out_y_o;
  logic [CHAN_W-1:0]    out_red_o;
  logic [CHAN_W-1:0]    out_green_o;
  logic [CHAN_W-1:0]    out_blue_o;
  logic [CHAN_W-1:0]    brightness_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CHAN_W-1:0]    cfg_data_i;

  ripple_scoreboard board;
  int               cycle_count = 0;
  int               phase_sent;

  radial_ripple_shader u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .time_phase_i (time_phase_i),
    .done_o       (done_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .brightness_o (brightness_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog: a stuck handshake or a lost result ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("no progress after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // monitor: everything is sampled at the edge, so pre-edge values are seen.
  // register writes and accepted pixels are noted before the result check
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.set_reg(cfg_index_i, cfg_data_i);
      if (start_i && !busy_o) board.note_pixel(pixel_x_i, pixel_y_i, time_phase_i);
      if (done_o)
        board.check_colour('{out_x_o, out_y_o, out_red_o, out_green_o, out_blue_o,
                             brightness_o});
    end
  end

  // one pixel transaction; returns just after the edge that took it
  task automatic send_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [PHASE_W-1:0] ph);
    start_i      <= 1'b1;
    pixel_x_i    <= x;
    pixel_y_i    <= y;
    time_phase_i <= ph;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // sender gap, start_i held low for the requested length
  task automatic pause(int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // hold off until every awaited colour has come out
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (board.awaited.size() != 0) @(posedge clk_i);
  endtask

  // register write transaction; valid stays up across back-to-back writes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CHAN_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // colour and level for one setting, extremes first, then random ones
  task automatic apply_setting(int setting);
    logic [CHAN_W-1:0]    red;
    logic [CHAN_W-1:0]    green;
    logic [CHAN_W-1:0]    blue;
    logic [CHAN_W-1:0]    cap;
    logic [CFG_IDX_W-1:0] junk_idx;
    red   = CHAN_W'($urandom_range(0, 255));
    green = CHAN_W'($urandom_range(0, 255));
    blue  = CHAN_W'($urandom_range(0, 255));
    cap   = CHAN_W'($urandom_range(0, 255));
    case (setting)
      1: begin
        red = '0; green = '0; blue = '0; cap = '0;
      end
      2: begin
        red = '1; green = '1; blue = '1; cap = '1;
      end
      3: begin
        red = '1; green = '0; blue = 8'd128;
      end
      4: cap = '0;
      5: cap = 8'd1;
      default: ;
    endcase
    write_reg(CFG_BASE_RED, red);
    write_reg(CFG_BASE_GREEN, green);
    write_reg(CFG_BASE_BLUE, blue);
    write_reg(CFG_MAX_LEVEL, cap);
    // a write outside the register map must change nothing
    if (setting % 2 == 1) junk_idx = '1;
    else junk_idx = CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, 255));
    write_reg(junk_idx, CHAN_W'($urandom_range(0, 255)));
    cfg_valid_i <= 1'b0;
  endtask

  // one pixel, with an occasional random sender gap in front of it when idling is set
  task automatic paced_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [PHASE_W-1:0] ph, bit idling);
    if (idling && $urandom_range(0, 7) == 0) pause($urandom_range(1, 18));
    send_pixel(x, y, ph);
    phase_sent++;
  endtask

  // mostly whole raster frames at one phase, as a panel would stream them,
  // the rest scattered pixels anywhere in the coordinate range
  task automatic run_phase(int count, bit idling);
    int                 row;
    int                 col;
    int                 k;
    logic [PHASE_W-1:0] frame_phase;
    bit                 drained;
    phase_sent = 0;
    drained = 1'b0;
    while (phase_sent < count) begin
      if ($urandom_range(0, 9) < 7) begin
        frame_phase = PHASE_W'($urandom_range(0, 65535));
        for (row = 0; row < GRID_H && phase_sent < count; row++)
          for (col = 0; col < GRID_W && phase_sent < count; col++)
            paced_pixel(COORD_W'(col), COORD_W'(row), frame_phase, idling);
      end else begin
        for (k = 0; k < 8 && phase_sent < count; k++)
          paced_pixel(COORD_W'($urandom_range(0, 63)), COORD_W'($urandom_range(0, 63)),
                      PHASE_W'($urandom_range(0, 65535)), idling);
      end
      // halfway through, when idling, let the pipeline run empty once
      if (idling && !drained && phase_sent >= count / 2) begin
        drain();
        drained = 1'b1;
      end
    end
  endtask

  initial begin
    int setting;
    board = new();
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    pixel_x_i    <= '0;
    pixel_y_i    <= '0;
    time_phase_i <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values: hand-picked pixels back to back, then random
    foreach (DIRECTED[i]) send_pixel(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].ph);
    run_phase(ITEMS_PER_SETTING, 1'b1);

    // registers change only with the pipeline empty; the last setting runs
    // without gaps, some earlier ones too
    for (setting = 1; setting < NUM_SETTINGS; setting++) begin
      drain();
      apply_setting(setting);
      run_phase(ITEMS_PER_SETTING, setting != NUM_SETTINGS - 1 && setting % 3 != 0);
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (board.awaited.size() != 0) begin
      $display("%0d colours never came out", board.awaited.size());
      board.failures += board.awaited.size();
    end

    $display("%0d pixels over %0d register settings: raster frames, off-grid pixels,",
             board.accepted, NUM_SETTINGS);
    $display("wave crest and trough, zero and full levels; %0d colours checked, %0d bad",
             board.checked, board.failures);
    if (board.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/rrs_pkg.sv
hdl/rrs_sqrt_stage.sv
hdl/rrs_sine_level.sv
hdl/rrs_colour_scale.sv
hdl/radial_ripple_shader.sv
hdl/rrs_checker.sv
tb/radial_ripple_shader_tb.sv
